@@ design/sclt_pkg.sv @@
// sclt_pkg: types, constants and the per-byte lexer step for the command-line tokenizer
`timescale 1ns / 1ps

package sclt_pkg;

    // limits of the lexer
    localparam int unsigned MAX_ARG_BYTES = 65535;
    localparam int unsigned MAX_ARGS      = 255;

    // number of results one input byte can cause at most
    localparam int unsigned RESULTS_MAX   = 4;

    // byte values the lexer looks at
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_SQUOTE = "'";
    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_LOW_N  = "n";
    localparam logic [7:0] CH_LOW_T  = "t";
    localparam logic [7:0] CH_UNDER  = "_";

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_ARG  = 6'b000010,
        MODE_SQ   = 6'b000100,
        MODE_DQ   = 6'b001000,
        MODE_VAR  = 6'b010000,
        MODE_DROP = 6'b100000
    } t_mode;

    typedef enum logic [2:0] {
        KIND_LIT      = 3'd0,
        KIND_VAR_BYTE = 3'd1,
        KIND_END_VAR  = 3'd2,
        KIND_END_ARG  = 3'd3,
        KIND_END_CMD  = 3'd4,
        KIND_ERROR    = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ERR_BACKSLASH = 3'd0,
        ERR_DOLLAR    = 3'd1,
        ERR_ILLEGAL   = 3'd2,
        ERR_SHORT_VAR = 3'd3,
        ERR_UNCLOSED  = 3'd4,
        ERR_TOO_LONG  = 3'd5
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [7:0]  count;
        logic [2:0]  code;
    } t_result;

    typedef struct packed {
        t_mode       mode;
        logic        esc;
        logic        ctx_dq;
        logic        dol;
        logic [7:0]  argc;
        logic [15:0] nbytes;
    } t_lex;

    typedef struct packed {
        t_lex                  st;
        t_result [RESULTS_MAX-1:0] res;
        logic [2:0]            num;
    } t_work;

    localparam t_lex LEX_RESET = '{MODE_IDLE, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0};

    function automatic logic f_is_sep(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_NUL);
    endfunction

    function automatic logic f_is_letter(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic f_is_name(logic [7:0] c);
        return f_is_letter(c) || ((c >= "0") && (c <= "9")) || (c == CH_UNDER);
    endfunction

    function automatic t_work f_emit(t_work w, t_kind kind, logic [7:0] data,
                                     logic [7:0] count, logic [2:0] code);
        t_work   v;
        t_result r;
        v = w;
        r.kind  = kind;
        r.data  = data;
        r.count = count;
        r.code  = code;
        if (v.num < 3'(RESULTS_MAX)) begin
            v.res[v.num[1:0]] = r;
            v.num = v.num + 3'd1;
        end
        return v;
    endfunction

    function automatic t_work f_fail(t_work w, t_err code);
        t_work v;
        v = f_emit(w, KIND_ERROR, 8'd0, 8'd0, code);
        v.st.mode = MODE_DROP;
        v.st.esc  = 1'b0;
        v.st.dol  = 1'b0;
        return v;
    endfunction

    // only literal bytes count toward the argument length
    function automatic t_work f_literal(t_work w, logic [7:0] c);
        t_work v;
        v = w;
        if (v.st.nbytes >= 16'(MAX_ARG_BYTES)) begin
            v = f_fail(v, ERR_TOO_LONG);
        end else begin
            v.st.nbytes = v.st.nbytes + 16'd1;
            v = f_emit(v, KIND_LIT, c, 8'd0, 3'd0);
        end
        return v;
    endfunction

    function automatic t_work f_escaped(t_work w, logic [7:0] c);
        t_work      v;
        logic [7:0] m;
        v = w;
        v.st.esc = 1'b0;
        if (c == CH_LOW_N) begin
            m = CH_NL;
        end else if (c == CH_LOW_T) begin
            m = CH_TAB;
        end else begin
            m = c;
        end
        return f_literal(v, m);
    endfunction

    function automatic t_work f_var_start(t_work w, logic [7:0] c, logic ctx_dq);
        t_work v;
        v = w;
        v.st.dol = 1'b0;
        if ((c <= CH_SPACE) || (c >= CH_DEL)) begin
            v = f_fail(v, ERR_ILLEGAL);
        end else if (f_is_letter(c)) begin
            v.st.mode   = MODE_VAR;
            v.st.ctx_dq = ctx_dq;
            v = f_emit(v, KIND_VAR_BYTE, c, 8'd0, 3'd0);
        end else begin
            v = f_fail(v, ERR_SHORT_VAR);
        end
        return v;
    endfunction

    function automatic t_work f_end_arg(t_work w);
        t_work v;
        v = f_emit(w, KIND_END_ARG, 8'd0, 8'd0, 3'd0);
        if (v.st.argc < 8'(MAX_ARGS)) begin
            v.st.argc = v.st.argc + 8'd1;
        end
        v.st.mode = MODE_IDLE;
        return v;
    endfunction

    // an empty command gives no end-of-command mark
    function automatic t_work f_end_cmd(t_work w);
        t_work v;
        v = w;
        if (v.st.argc != 8'd0) begin
            v = f_emit(v, KIND_END_CMD, 8'd0, v.st.argc, 3'd0);
        end
        v.st.argc = 8'd0;
        return v;
    endfunction

    function automatic t_work f_idle(t_work w, logic [7:0] c);
        t_work v;
        v = w;
        if (f_is_sep(c)) begin
            v = w;
        end else if (c == CH_SEMI) begin
            v = f_end_cmd(v);
        end else begin
            v.st.mode   = MODE_ARG;
            v.st.nbytes = 16'd0;
            if (c == CH_BSLASH) begin
                v.st.esc = 1'b1;
            end else if (c == CH_DOLLAR) begin
                v.st.dol = 1'b1;
            end else if (c == CH_SQUOTE) begin
                v.st.mode = MODE_SQ;
            end else if (c == CH_DQUOTE) begin
                v.st.mode = MODE_DQ;
            end else begin
                v = f_literal(v, c);
            end
        end
        return v;
    endfunction

    function automatic t_work f_arg(t_work w, logic [7:0] c);
        t_work v;
        v = w;
        if (v.st.esc) begin
            v = f_escaped(v, c);
        end else if (v.st.dol) begin
            v = f_var_start(v, c, 1'b0);
        end else if (c == CH_SEMI) begin
            v = f_end_arg(v);
            v = f_end_cmd(v);
        end else if (f_is_sep(c)) begin
            v = f_end_arg(v);
        end else if (c == CH_BSLASH) begin
            v.st.esc = 1'b1;
        end else if (c == CH_DOLLAR) begin
            v.st.dol = 1'b1;
        end else if (c == CH_SQUOTE) begin
            v.st.mode = MODE_SQ;
        end else if (c == CH_DQUOTE) begin
            v.st.mode = MODE_DQ;
        end else begin
            v = f_literal(v, c);
        end
        return v;
    endfunction

    function automatic t_work f_sq(t_work w, logic [7:0] c);
        t_work v;
        v = w;
        if (v.st.esc) begin
            v = f_escaped(v, c);
        end else if (c == CH_SQUOTE) begin
            v.st.mode = MODE_ARG;
        end else if (c == CH_BSLASH) begin
            v.st.esc = 1'b1;
        end else begin
            v = f_literal(v, c);
        end
        return v;
    endfunction

    function automatic t_work f_dq(t_work w, logic [7:0] c);
        t_work v;
        v = w;
        if (v.st.esc) begin
            v = f_escaped(v, c);
        end else if (v.st.dol) begin
            v = f_var_start(v, c, 1'b1);
        end else if (c == CH_DQUOTE) begin
            v.st.mode = MODE_ARG;
        end else if (c == CH_BSLASH) begin
            v.st.esc = 1'b1;
        end else if (c == CH_DOLLAR) begin
            v.st.dol = 1'b1;
        end else begin
            v = f_literal(v, c);
        end
        return v;
    endfunction

    function automatic t_work f_finish(t_work w);
        t_work v;
        v = w;
        if (v.st.esc) begin
            v = f_fail(v, ERR_BACKSLASH);
        end else if (v.st.dol) begin
            v = f_fail(v, ERR_DOLLAR);
        end else begin
            if (v.st.mode == MODE_VAR) begin
                v = f_emit(v, KIND_END_VAR, 8'd0, 8'd0, 3'd0);
                v.st.mode = v.st.ctx_dq ? MODE_DQ : MODE_ARG;
            end
            if ((v.st.mode == MODE_SQ) || (v.st.mode == MODE_DQ)) begin
                v = f_fail(v, ERR_UNCLOSED);
            end else begin
                if (v.st.mode == MODE_ARG) begin
                    v = f_end_arg(v);
                end
                v = f_end_cmd(v);
            end
        end
        return v;
    endfunction

    // whole work for one byte: new lexer state and the results it causes
    function automatic t_work f_step(t_lex st, logic [7:0] c, logic eol);
        t_work w;
        logic  done;
        w    = '0;
        w.st = st;
        done = 1'b0;
        // an open name either takes the byte or closes and hands it on
        if (w.st.mode == MODE_VAR) begin
            if (f_is_name(c)) begin
                w    = f_emit(w, KIND_VAR_BYTE, c, 8'd0, 3'd0);
                done = 1'b1;
            end else begin
                w = f_emit(w, KIND_END_VAR, 8'd0, 8'd0, 3'd0);
                w.st.mode = w.st.ctx_dq ? MODE_DQ : MODE_ARG;
            end
        end
        if (!done) begin
            case (w.st.mode)
                MODE_IDLE: w = f_idle(w, c);
                MODE_ARG:  w = f_arg(w, c);
                MODE_SQ:   w = f_sq(w, c);
                MODE_DQ:   w = f_dq(w, c);
                default:   w.st.mode = MODE_DROP;
            endcase
        end
        if (eol) begin
            if (w.st.mode != MODE_DROP) begin
                w = f_finish(w);
            end
            w.st = LEX_RESET;
        end
        return w;
    endfunction

endpackage

@@ design/shell_command_line_tokenizer_unit.sv @@
// shell_command_line_tokenizer_unit: byte-serial shell word splitter with quoting and $name marks
`timescale 1ns / 1ps

// Takes one command-line byte per transfer (i_line_end set on the last byte of the line) and
// splits it into tagged results: literal bytes, variable-name bytes, end-of-variable,
// end-of-argument, end-of-command (with the saturating argument count) and errors. Quotes,
// backslash escapes and $name references are resolved here; variable lookup is not. After an
// error nothing more comes out until the line's last byte, which restores the idle state.
// A byte is held in an input register, then its whole lexer step runs combinationally and loads
// up to four results into a result group register, which hands them out one per transfer.
// Bytes causing zero or one result stream at one per cycle while the output is not stalled;
// a byte with more results holds the input until its last result is taken. A result passes
// through the input register and then the result group register before it is valid.
// The o_last flag marks the final result caused by a byte.
module shell_command_line_tokenizer_unit
    import sclt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_line_end,
    // result output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_byte_out,
    output logic [7:0] o_arg_count,
    output logic [2:0] o_error_code,
    output logic       o_last
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_eol;

    // lexer state
    t_lex       r_st;

    // result group register: results of one byte, drained one per transfer
    t_result [RESULTS_MAX-1:0] r_res;
    logic [2:0]                r_num;
    logic [1:0]                r_idx;

    t_work   w_work;
    t_result w_cur;
    logic    w_group_last;
    logic    w_out_xfer;
    logic    w_advance;

    // whole step for the buffered byte
    always_comb begin
        w_work = f_step(r_st, r_in_ch, r_in_eol);
    end

    assign w_cur        = r_res[r_idx];
    assign w_group_last = ({1'b0, r_idx} == (r_num - 3'd1));
    assign o_out_valid  = (r_num != 3'd0);
    assign w_out_xfer   = o_out_valid && i_out_ready;

    // byte moves on once the group register is free or gives up its final result now
    assign w_advance    = r_in_valid && (!o_out_valid || (w_out_xfer && w_group_last));
    assign o_in_ready   = !r_in_valid || w_advance;

    assign o_kind       = w_cur.kind;
    assign o_byte_out   = w_cur.data;
    assign o_arg_count  = w_cur.count;
    assign o_error_code = w_cur.code;
    assign o_last       = w_group_last;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_ch  <= i_ch;
            r_in_eol <= i_line_end;
        end
    end

    // lexer state and group bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= LEX_RESET;
            r_num <= 3'd0;
            r_idx <= 2'd0;
        end else if (w_advance) begin
            r_st  <= w_work.st;
            r_num <= w_work.num;
            r_idx <= 2'd0;
        end else if (w_out_xfer) begin
            if (w_group_last) begin
                r_num <= 3'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_work.res;
        end
    end

    // read pointer stays inside the loaded group
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, r_idx} < r_num))
        else $error("result pointer outside group");

    // an error ends all output of its byte
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_ERROR)) |-> o_last)
        else $error("error result not last of its group");

    // end-of-command always carries a count
    a_cmd_has_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_END_CMD)) |-> (o_arg_count != 8'd0))
        else $error("end of command with zero arguments");

    // the last byte of a line leaves the lexer idle
    a_line_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_eol) |=> (r_st == LEX_RESET))
        else $error("lexer state not idle after line end");

endmodule
